@@ rtl/cfea_pkg.sv @@
package cfea_pkg;

  // defaults for the top-level parameters
  localparam int DEF_MAX_FACE_SIZE = 4096;
  localparam int DEF_MAX_SRC_WIDTH = 8192;
  localparam int DEF_CORDIC_STAGES = 16;

  // register and field widths
  localparam int FS_W       = 13;
  localparam int SW_W       = 14;
  localparam int SH_W       = 13;
  localparam int FACE_W     = 3;
  localparam int PIX_W      = 12;
  localparam int COL_W      = 13;
  localparam int ROW_W      = 12;
  localparam int IDX_W      = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // datapath widths
  localparam int QUO_W = 17;  // (2p+1)*2^16/f < 2^17
  localparam int D_W   = 24;  // CORDIC x/y, Q2.16 plus growth
  localparam int ANG_W = 21;  // angle, radians Q.16
  localparam int NU_W  = 19;  // clamped angle numerator

  // fixed-point constants
  localparam int ONE_Q     = 65536;
  localparam int PI_Q      = 205887;
  localparam int HALF_PI_Q = 102944;
  localparam int TWO_PI_Q  = 411774;
  localparam int GAIN_Q    = 107922;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACE_SIZE  = 2'd0,
    CFG_SRC_WIDTH  = 2'd1,
    CFG_SRC_HEIGHT = 2'd2
  } cfg_reg_t;

  localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;

  // round(atan(2^-i) * 2^16); zero from i = 17 on
  function automatic logic signed [ANG_W-1:0] atan_q(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:  v = 21'sd51472;
      1:  v = 21'sd30386;
      2:  v = 21'sd16055;
      3:  v = 21'sd8150;
      4:  v = 21'sd4091;
      5:  v = 21'sd2047;
      6:  v = 21'sd1024;
      7:  v = 21'sd512;
      8:  v = 21'sd256;
      9:  v = 21'sd128;
      10: v = 21'sd64;
      11: v = 21'sd32;
      12: v = 21'sd16;
      13: v = 21'sd8;
      14: v = 21'sd4;
      15: v = 21'sd2;
      16: v = 21'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/cfea_coord_div.sv @@
// Two-lane restoring divider, one quotient bit per stage:
// q = ((2p+1) << 16) / f with p saturated at f-1.
module cfea_coord_div #(
  parameter int TAG_W = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [cfea_pkg::PIX_W-1:0]  in_px,
  input  logic [cfea_pkg::PIX_W-1:0]  in_py,
  input  logic [cfea_pkg::FS_W-1:0]   f,
  input  logic [TAG_W-1:0]            in_tag,
  output logic                        out_v,
  output logic [cfea_pkg::QUO_W-1:0]  out_qa,
  output logic [cfea_pkg::QUO_W-1:0]  out_qb,
  output logic [TAG_W-1:0]            out_tag
);
  import cfea_pkg::*;

  logic [FS_W-1:0]  fm1;
  logic [FS_W-1:0]  psat [2];
  logic [FS_W-1:0]  rem_r [QUO_W][2];
  logic [QUO_W-1:0] q_r   [QUO_W][2];
  logic             v_r   [QUO_W];
  logic [TAG_W-1:0] tag_r [QUO_W];

  // initial remainder is p itself (p < f after saturation)
  always_comb begin
    fm1     = f - FS_W'(1);
    psat[0] = ({1'b0, in_px} > fm1) ? fm1 : {1'b0, in_px};
    psat[1] = ({1'b0, in_py} > fm1) ? fm1 : {1'b0, in_py};
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_st
    logic [FS_W-1:0]  rem_i [2];
    logic [QUO_W-1:0] q_i   [2];
    logic             v_i;
    logic [TAG_W-1:0] tag_i;
    logic [FS_W:0]    sh    [2];
    logic [FS_W:0]    df    [2];
    logic             ge    [2];

    if (k == 0) begin : g_in
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          rem_i[l] = psat[l];
          q_i[l]   = '0;
        end
        v_i   = in_v;
        tag_i = in_tag;
      end
    end else begin : g_mid
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          rem_i[l] = rem_r[k-1][l];
          q_i[l]   = q_r[k-1][l];
        end
        v_i   = v_r[k-1];
        tag_i = tag_r[k-1];
      end
    end

    // numerator bit 16 is the +1, all lower bits are zero
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        sh[l] = {rem_i[l], (k == 0) ? 1'b1 : 1'b0};
        df[l] = sh[l] - {1'b0, f};
        ge[l] = (sh[l] >= {1'b0, f});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          rem_r[k][l] <= ge[l] ? df[l][FS_W-1:0] : sh[l][FS_W-1:0];
          q_r[k][l]   <= {q_i[l][QUO_W-2:0], ge[l]};
        end
        tag_r[k] <= tag_i;
      end
    end
  end

  assign out_v   = v_r[QUO_W-1];
  assign out_qa  = q_r[QUO_W-1][0];
  assign out_qb  = q_r[QUO_W-1][1];
  assign out_tag = tag_r[QUO_W-1];

endmodule

@@ rtl/cfea_cordic.sv @@
// Vectoring CORDIC, one micro-rotation per stage. Returns atan2(y, x)
// and K times the magnitude; a zero vector gives zero for both.
module cfea_cordic #(
  parameter int STAGES = cfea_pkg::DEF_CORDIC_STAGES,
  parameter int TAG_W  = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_v,
  input  logic signed [cfea_pkg::D_W-1:0]   in_x,
  input  logic signed [cfea_pkg::D_W-1:0]   in_y,
  input  logic [TAG_W-1:0]                  in_tag,
  output logic                              out_v,
  output logic signed [cfea_pkg::D_W-1:0]   out_mag,
  output logic signed [cfea_pkg::ANG_W-1:0] out_ang,
  output logic [TAG_W-1:0]                  out_tag
);
  import cfea_pkg::*;

  logic signed [D_W-1:0]   px_nxt, py_nxt, px_r, py_r;
  logic signed [ANG_W-1:0] pa_nxt, pa_r;
  logic                    pz_nxt, pz_r, pv_r;
  logic [TAG_W-1:0]        ptag_r;

  logic signed [D_W-1:0]   x_r   [STAGES];
  logic signed [D_W-1:0]   y_r   [STAGES];
  logic signed [ANG_W-1:0] a_r   [STAGES];
  logic                    z_r   [STAGES];
  logic                    v_r   [STAGES];
  logic [TAG_W-1:0]        tag_r [STAGES];

  // pre-rotation by +-90 deg brings x into the right half plane
  always_comb begin
    pz_nxt = (in_x == '0) && (in_y == '0);
    px_nxt = in_x;
    py_nxt = in_y;
    pa_nxt = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        px_nxt = in_y;
        py_nxt = -in_x;
        pa_nxt = ANG_W'(HALF_PI_Q);
      end else begin
        px_nxt = -in_y;
        py_nxt = in_x;
        pa_nxt = -ANG_W'(HALF_PI_Q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      pa_r   <= pa_nxt;
      pz_r   <= pz_nxt;
      ptag_r <= in_tag;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_it
    logic signed [D_W-1:0]   xi, yi, dx, dy, xn, yn;
    logic signed [ANG_W-1:0] ai, an;
    logic                    zi, vi;
    logic [TAG_W-1:0]        ti;

    if (k == 0) begin : g_in
      always_comb begin
        xi = px_r;
        yi = py_r;
        ai = pa_r;
        zi = pz_r;
        vi = pv_r;
        ti = ptag_r;
      end
    end else begin : g_mid
      always_comb begin
        xi = x_r[k-1];
        yi = y_r[k-1];
        ai = a_r[k-1];
        zi = z_r[k-1];
        vi = v_r[k-1];
        ti = tag_r[k-1];
      end
    end

    always_comb begin
      dx = yi >>> k;
      dy = xi >>> k;
      if (yi >= 0) begin
        xn = xi + dx;
        yn = yi - dy;
        an = ai + atan_q(k);
      end else begin
        xn = xi - dx;
        yn = yi + dy;
        an = ai - atan_q(k);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= xn;
        y_r[k]   <= yn;
        a_r[k]   <= an;
        z_r[k]   <= zi;
        tag_r[k] <= ti;
      end
    end
  end

  assign out_v   = v_r[STAGES-1];
  assign out_mag = z_r[STAGES-1] ? '0 : x_r[STAGES-1];
  assign out_ang = z_r[STAGES-1] ? '0 : a_r[STAGES-1];
  assign out_tag = tag_r[STAGES-1];

endmodule

@@ rtl/cfea_cdiv.sv @@
// q = floor(n * f / 2pi) by reciprocal multiply and one correction step.
module cfea_cdiv #(
  parameter int F_W = cfea_pkg::SW_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_v,
  input  logic [cfea_pkg::NU_W-1:0]  in_n,
  input  logic [F_W-1:0]             in_f,
  output logic                       out_v,
  output logic [F_W:0]               out_q
);
  import cfea_pkg::*;

  localparam int N_W = NU_W + F_W;
  localparam int M_W = N_W - 18;  // 2pi in Q.16 exceeds 2^18
  localparam longint unsigned RECIP = (64'd1 << N_W) / TWO_PI_Q;
  localparam logic [M_W-1:0] RECIP_M = M_W'(RECIP);

  logic [3:0]         v_r;
  logic [N_W-1:0]     n1_r, n2_r, n3_r, pr3_r, rem;
  logic [N_W+M_W-1:0] p2_r;
  logic [M_W-1:0]     q0, q0_r, q4_r;

  assign q0  = p2_r[N_W+M_W-1:N_W];
  assign rem = n3_r - pr3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r  <= {{F_W{1'b0}}, in_n} * {{NU_W{1'b0}}, in_f};
      p2_r  <= {{M_W{1'b0}}, n1_r} * {{N_W{1'b0}}, RECIP_M};
      n2_r  <= n1_r;
      q0_r  <= q0;
      n3_r  <= n2_r;
      pr3_r <= N_W'(q0) * N_W'(TWO_PI_Q);
      q4_r  <= q0_r + M_W'(rem >= N_W'(TWO_PI_Q));
    end
  end

  assign out_v = v_r[3];
  assign out_q = q4_r[F_W:0];

endmodule

@@ rtl/cube_face_to_equirect_address_core.sv @@
// Cube-face pixel to equirectangular texel address.
// Input channel (in_valid/in_ready): one word per cube-face pixel, with
// face_id (0..5 = +X,-X,+Y,-Y,+Z,-Z; 6 and 7 act as -Z), face_x, face_y.
// Output channel (out_valid/out_ready): one word per input word, in order:
// src_col, src_row and texel_index = row * width + col.
// Config port: cfg_we writes cfg_wdata to face_size (0), src_width (1) or
// src_height (2) in the same cycle; other indexes are ignored. Write only
// while the block is empty; new values take effect once the registered effective copy has loaded them.
// Throughput: one word per clock while the skid register is empty. The pipe
// has 2*CORDIC_STAGES + 29 register stages (17 divider stages, two CORDICs
// of CORDIC_STAGES+1 stages, 4 reciprocal-divide stages, and the input,
// direction, gain, wrap/clamp, index and output registers); the accepting
// edge loads the first.
// Reset: pipeline emptied, registers back to 512 / 2048 / 1024.
// Stall: a skid register behind the output register takes one more word
// while out_ready is low; the whole pipe then freezes and in_ready drops
// until the skid register drains. Nothing is dropped or repeated.
module cube_face_to_equirect_address_core #(
  parameter int MAX_FACE_SIZE = cfea_pkg::DEF_MAX_FACE_SIZE,
  parameter int MAX_SRC_WIDTH = cfea_pkg::DEF_MAX_SRC_WIDTH,
  parameter int CORDIC_STAGES = cfea_pkg::DEF_CORDIC_STAGES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cfea_pkg::FACE_W-1:0]      in_face_id,
  input  logic [cfea_pkg::PIX_W-1:0]       in_face_x,
  input  logic [cfea_pkg::PIX_W-1:0]       in_face_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cfea_pkg::COL_W-1:0]       out_src_col,
  output logic [cfea_pkg::ROW_W-1:0]       out_src_row,
  output logic [cfea_pkg::IDX_W-1:0]       out_texel_index,
  input  logic                             cfg_we,
  input  logic [cfea_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfea_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cfea_pkg::*;

  // ---------------- configuration ----------------
  logic [FS_W-1:0] fs_r, f_eff_nxt, f_eff_r;
  logic [SW_W-1:0] sw_r, w_eff_nxt, w_eff_r;
  logic [SH_W-1:0] sh_r, h_eff_nxt, h_eff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FS_W'(512);
      sw_r <= SW_W'(2048);
      sh_r <= SH_W'(1024);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FACE_SIZE:  fs_r <= cfg_wdata[FS_W-1:0];
        CFG_SRC_WIDTH:  sw_r <= cfg_wdata[SW_W-1:0];
        CFG_SRC_HEIGHT: sh_r <= cfg_wdata[SH_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one; face size and width saturate at their maxima
  always_comb begin
    f_eff_nxt = fs_r;
    if (fs_r == '0) f_eff_nxt = FS_W'(1);
    else if (int'(fs_r) > MAX_FACE_SIZE) f_eff_nxt = FS_W'(MAX_FACE_SIZE);
    w_eff_nxt = sw_r;
    if (sw_r == '0) w_eff_nxt = SW_W'(1);
    else if (int'(sw_r) > MAX_SRC_WIDTH) w_eff_nxt = SW_W'(MAX_SRC_WIDTH);
    h_eff_nxt = (sh_r == '0) ? SH_W'(1) : sh_r;
  end

  always_ff @(posedge clk) begin
    f_eff_r <= f_eff_nxt;
    w_eff_r <= w_eff_nxt;
    h_eff_r <= h_eff_nxt;
  end

  // ---------------- flow control ----------------
  // Every stage advances together; the pipe only freezes when the skid
  // register is occupied.
  logic en;
  logic skid_v_r, out_valid_r;

  assign en       = ~skid_v_r;
  assign in_ready = en;

  // ---------------- input register ----------------
  logic             s0_v_r;
  logic [FACE_W-1:0] s0_face_r;
  logic [PIX_W-1:0]  s0_x_r, s0_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_face_r <= in_face_id;
      s0_x_r    <= in_face_x;
      s0_y_r    <= in_face_y;
    end
  end

  // ---------------- face coordinates a, b ----------------
  logic              dv_v;
  logic [QUO_W-1:0]  qa, qb;
  logic [FACE_W-1:0] dv_face;

  cfea_coord_div #(
    .TAG_W (FACE_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (s0_v_r),
    .in_px   (s0_x_r),
    .in_py   (s0_y_r),
    .f       (f_eff_r),
    .in_tag  (s0_face_r),
    .out_v   (dv_v),
    .out_qa  (qa),
    .out_qb  (qb),
    .out_tag (dv_face)
  );

  // ---------------- direction vector ----------------
  logic signed [D_W-1:0] ca, cb, one_q;
  logic signed [D_W-1:0] dx_nxt, dy_nxt, dz_nxt, dx_r, dy_r, dz_r;
  logic                  dir_v_r;

  always_comb begin
    one_q = D_W'(ONE_Q);
    ca    = $signed({{(D_W-QUO_W){1'b0}}, qa}) - one_q;
    cb    = $signed({{(D_W-QUO_W){1'b0}}, qb}) - one_q;
    case (dv_face)
      FACE_PX: begin dx_nxt = one_q;  dy_nxt = -cb;    dz_nxt = -ca;    end
      FACE_NX: begin dx_nxt = -one_q; dy_nxt = -cb;    dz_nxt = ca;     end
      FACE_PY: begin dx_nxt = ca;     dy_nxt = one_q;  dz_nxt = cb;     end
      FACE_NY: begin dx_nxt = ca;     dy_nxt = -one_q; dz_nxt = -cb;    end
      FACE_PZ: begin dx_nxt = ca;     dy_nxt = -cb;    dz_nxt = one_q;  end
      default: begin dx_nxt = -ca;    dy_nxt = -cb;    dz_nxt = -one_q; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_v_r <= 1'b0;
    end else if (en) begin
      dir_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      dz_r <= dz_nxt;
    end
  end

  // ---------------- CORDIC gain on the vertical component ----------------
  // sign-magnitude product, truncated toward zero
  logic [16:0]           ymag;
  logic [33:0]           yprod;
  logic signed [D_W-1:0] ysc, gx_r, gy_r, gz_r;
  logic                  g_v_r;

  always_comb begin
    ymag  = (dy_r < 0) ? 17'(-dy_r) : 17'(dy_r);
    yprod = {17'd0, ymag} * 34'(GAIN_Q);
    ysc   = $signed({{(D_W-18){1'b0}}, yprod[33:16]});
    if (dy_r < 0) ysc = -ysc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= dir_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx_r <= dx_r;
      gz_r <= dz_r;
      gy_r <= ysc;
    end
  end

  // ---------------- longitude: theta = atan2(z, x) ----------------
  logic                    c1_v;
  logic signed [D_W-1:0]   c1_mag, c1_y;
  logic signed [ANG_W-1:0] theta;

  cfea_cordic #(
    .STAGES (CORDIC_STAGES),
    .TAG_W  (D_W)
  ) u_cordic_lon (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (g_v_r),
    .in_x    (gx_r),
    .in_y    (gz_r),
    .in_tag  (gy_r),
    .out_v   (c1_v),
    .out_mag (c1_mag),
    .out_ang (theta),
    .out_tag (c1_y)
  );

  // ---------------- latitude: phi = atan2(K*y, K*r) ----------------
  logic                    c2_v;
  logic signed [ANG_W-1:0] phi, theta2;

  cfea_cordic #(
    .STAGES (CORDIC_STAGES),
    .TAG_W  (ANG_W)
  ) u_cordic_lat (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (c1_v),
    .in_x    (c1_mag),
    .in_y    (c1_y),
    .in_tag  (theta),
    .out_v   (c2_v),
    .out_mag (),
    .out_ang (phi),
    .out_tag (theta2)
  );

  // ---------------- angle to texel coordinates ----------------
  logic signed [ANG_W:0]   nu_s;
  logic signed [ANG_W+1:0] nv_s;
  logic [NU_W-1:0]         nu, nv;

  always_comb begin
    nu_s = $signed({theta2[ANG_W-1], theta2}) + (ANG_W+1)'(PI_Q);
    nv_s = (ANG_W+2)'(PI_Q) - ($signed({{2{phi[ANG_W-1]}}, phi}) <<< 1);
    nu   = (nu_s < 0) ? '0 : nu_s[NU_W-1:0];
    nv   = (nv_s < 0) ? '0 : nv_s[NU_W-1:0];
  end

  logic            cd_v;
  logic [SW_W:0]   qcol;
  logic [SH_W:0]   qrow;

  cfea_cdiv #(
    .F_W (SW_W)
  ) u_cdiv_col (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (c2_v),
    .in_n  (nu),
    .in_f  (w_eff_r),
    .out_v (cd_v),
    .out_q (qcol)
  );

  cfea_cdiv #(
    .F_W (SH_W)
  ) u_cdiv_row (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (c2_v),
    .in_n  (nv),
    .in_f  (h_eff_r),
    .out_v (),
    .out_q (qrow)
  );

  // ---------------- wrap column, clamp row ----------------
  // quotient stays below twice the size, so one subtract wraps
  logic            fin_v_r;
  logic [SW_W:0]   cdiff;
  logic [SW_W-1:0] col_nxt, col_r;
  logic [SH_W-1:0] row_nxt, row_r;

  always_comb begin
    cdiff   = qcol - {1'b0, w_eff_r};
    col_nxt = (qcol >= {1'b0, w_eff_r}) ? cdiff[SW_W-1:0] : qcol[SW_W-1:0];
    row_nxt = (qrow >= {1'b0, h_eff_r}) ? (h_eff_r - SH_W'(1)) : qrow[SH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= cd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- linear index ----------------
  logic                 tm_v_r;
  logic [SH_W+SW_W-1:0] tprod_r, tidx;
  logic [SW_W-1:0]      tcol_r;
  logic [SH_W-1:0]      trow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tm_v_r <= 1'b0;
    end else if (en) begin
      tm_v_r <= fin_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tprod_r <= {{SW_W{1'b0}}, row_r} * {{SH_W{1'b0}}, w_eff_r};
      tcol_r  <= col_r;
      trow_r  <= row_r;
    end
  end

  assign tidx = tprod_r + (SH_W+SW_W)'(tcol_r);

  // ---------------- output register and skid register ----------------
  logic [COL_W-1:0] oc_r, sc_r;
  logic [ROW_W-1:0] or_r, sr_r;
  logic [IDX_W-1:0] oi_r, si_r;
  logic             out_load, inc_v;

  assign out_load = ~out_valid_r | out_ready;
  assign inc_v    = en & tm_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= skid_v_r | inc_v;
      skid_v_r    <= 1'b0;
    end else if (inc_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_v_r) begin
        oc_r <= sc_r;
        or_r <= sr_r;
        oi_r <= si_r;
      end else begin
        oc_r <= tcol_r[COL_W-1:0];
        or_r <= trow_r[ROW_W-1:0];
        oi_r <= tidx[IDX_W-1:0];
      end
    end else if (inc_v) begin
      sc_r <= tcol_r[COL_W-1:0];
      sr_r <= trow_r[ROW_W-1:0];
      si_r <= tidx[IDX_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_src_col     = oc_r;
  assign out_src_row     = or_r;
  assign out_texel_index = oi_r;

  // ---------------- assertions ----------------
  // skid register only fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid word without output word");

  // a held skid word survives until the output drains
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_valid_r && !out_ready) |=> (skid_v_r && out_valid_r))
    else $error("skid word lost during stall");

  // an accepted word always lands in the input stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s0_v_r)
    else $error("accepted word not captured");

  // reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !skid_v_r))
    else $error("output not empty after reset");

endmodule

@@ tb/tb_cube_face_to_equirect_address_core.sv @@
module tb_cube_face_to_equirect_address_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cfea_pkg::*;

  // 2*16+29 register stages from accept to out_valid
  localparam int PIPE_DEPTH  = 61;
  localparam int SETTLE      = PIPE_DEPTH + 10;
  localparam int STALL_LIMIT = 5000;
  // index with no register behind it; writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  localparam logic [FACE_W-1:0] FACE_NZ  = 3'd5;
  localparam logic [FACE_W-1:0] FACE_ALT6 = 3'd6;
  localparam logic [FACE_W-1:0] FACE_ALT7 = 3'd7;

  typedef struct {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [IDX_W-1:0] idx;
  } texel_addr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FACE_W-1:0] in_face_id = '0;
  logic [PIX_W-1:0] in_face_x = '0;
  logic [PIX_W-1:0] in_face_y = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [COL_W-1:0] out_src_col;
  logic [ROW_W-1:0] out_src_row;
  logic [IDX_W-1:0] out_texel_index;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow copy of the config registers
  logic [FS_W-1:0] face_size_q  = 13'd512;
  logic [SW_W-1:0] src_width_q  = 14'd2048;
  logic [SH_W-1:0] src_height_q = 13'd1024;

  texel_addr_t pending_addrs[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int idle_cnt = 0;
  // percent of cycles the sender idles / the receiver stalls
  int idle_pct = 0;
  int stall_pct = 0;

  always #1 clk = ~clk;

  cube_face_to_equirect_address_core dut (.*);

  // ---------------------------------------------------------------
  // address predictor
  // ---------------------------------------------------------------
  function automatic longint atan_step(int i);
    longint tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 17) ? tab[i] : 0;
  endfunction

  // vectoring CORDIC; returns angle, magnitude (with gain) through mag
  function automatic longint vector_angle(longint xv, longint yv, output longint mag);
    longint ang, t, sx, sy;
    ang = 0;
    if (xv == 0 && yv == 0) begin
      mag = 0;
      return 0;
    end
    // pre-rotate left half plane by +-pi/2
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; ang = HALF_PI_Q;
      end else begin
        xv = -yv; yv = t; ang = -HALF_PI_Q;
      end
    end
    for (int i = 0; i < DEF_CORDIC_STAGES; i++) begin
      sx = yv >>> i;
      sy = xv >>> i;
      if (yv >= 0) begin
        xv += sx; yv -= sy; ang += atan_step(i);
      end else begin
        xv -= sx; yv += sy; ang -= atan_step(i);
      end
    end
    mag = xv;
    return ang;
  endfunction

  function automatic longint pixel_coord(longint p, longint f);
    if (p > f - 1) p = f - 1;
    return (((2 * p + 1) << 16) / f) - ONE_Q;
  endfunction

  function automatic texel_addr_t predict_addr(logic [FACE_W-1:0] face,
                                               logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    longint f, w, h, a, b, dx, dy, dz, theta, phi, rmag, dummy, ky, nu, nv, col, row;
    longint lin;
    texel_addr_t r;
    f = face_size_q;  w = src_width_q;  h = src_height_q;
    if (f == 0) f = 1;
    if (f > DEF_MAX_FACE_SIZE) f = DEF_MAX_FACE_SIZE;
    if (w == 0) w = 1;
    if (w > DEF_MAX_SRC_WIDTH) w = DEF_MAX_SRC_WIDTH;
    if (h == 0) h = 1;
    a = pixel_coord(px, f);
    b = pixel_coord(py, f);
    case (face)
      FACE_PX: begin dx = ONE_Q;  dy = -b;     dz = -a;     end
      FACE_NX: begin dx = -ONE_Q; dy = -b;     dz = a;      end
      FACE_PY: begin dx = a;      dy = ONE_Q;  dz = b;      end
      FACE_NY: begin dx = a;      dy = -ONE_Q; dz = -b;     end
      FACE_PZ: begin dx = a;      dy = -b;     dz = ONE_Q;  end
      default: begin dx = -a;     dy = -b;     dz = -ONE_Q; end  // -Z, 6, 7
    endcase
    theta = vector_angle(dx, dz, rmag);
    // gain product truncates toward zero
    ky = (dy >= 0) ? ((dy * GAIN_Q) >>> 16) : -(((-dy) * GAIN_Q) >>> 16);
    phi = vector_angle(rmag, ky, dummy);
    nu = (theta + PI_Q < 0) ? 0 : theta + PI_Q;
    col = (nu * w / TWO_PI_Q) % w;
    nv = (PI_Q - 2 * phi < 0) ? 0 : PI_Q - 2 * phi;
    row = nv * h / TWO_PI_Q;
    if (row >= h) row = h - 1;
    lin = row * w + col;
    r.col = col[COL_W-1:0];
    r.row = row[ROW_W-1:0];
    r.idx = lin[IDX_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want, words_out);
    errors++;
  endtask

  always @(posedge clk) begin
    texel_addr_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_addrs.size() == 0) begin
        report_mismatch("unexpected word", out_texel_index, -1);
      end else begin
        want = pending_addrs.pop_front();
        if (out_src_col !== want.col) report_mismatch("src_col", out_src_col, want.col);
        if (out_src_row !== want.row) report_mismatch("src_row", out_src_row, want.row);
        if (out_texel_index !== want.idx)
          report_mismatch("texel_index", out_texel_index, want.idx);
      end
      words_out++;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------
  // holds valid until the word is taken, then may drop valid for a random gap
  task automatic send_pixel(logic [FACE_W-1:0] face, logic [PIX_W-1:0] px,
                            logic [PIX_W-1:0] py);
    in_valid   <= 1'b1;
    in_face_id <= face;
    in_face_x  <= px;
    in_face_y  <= py;
    do @(posedge clk); while (!in_ready);
    pending_addrs.push_back(predict_addr(face, px, py));
    words_in++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all three registers back to back, plus a dropped write
  task automatic load_regs(int fs, int sw, int sh);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_FACE_SIZE;   cfg_wdata <= CFG_DATA_W'(fs);
    @(posedge clk);
    face_size_q = FS_W'(fs);
    cfg_index <= CFG_SRC_WIDTH;   cfg_wdata <= CFG_DATA_W'(sw);
    @(posedge clk);
    src_width_q = SW_W'(sw);
    cfg_index <= CFG_SRC_HEIGHT;  cfg_wdata <= CFG_DATA_W'(sh);
    @(posedge clk);
    src_height_q = SH_W'(sh);
    cfg_index <= CFG_NONE;        cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    int f;
    f = (face_size_q == 0) ? 1 : (face_size_q > DEF_MAX_FACE_SIZE) ? DEF_MAX_FACE_SIZE
                                                                    : face_size_q;
    if ($urandom_range(99) < 15) return PIX_W'($urandom);  // may fall outside the face
    return PIX_W'($urandom_range(f - 1));
  endfunction

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------
  task automatic test_directed();
    load_regs(512, 2048, 1024);
    // every face code at the face center, incl. the -Z aliases
    for (int fc = 0; fc < 8; fc++) send_pixel(FACE_W'(fc), 12'd256, 12'd256);
    // face corners hit the seams and poles
    send_pixel(FACE_PX, 12'd0, 12'd0);
    send_pixel(FACE_NX, 12'd511, 12'd511);
    send_pixel(FACE_PY, 12'd0, 12'd511);
    send_pixel(FACE_NY, 12'd511, 12'd0);
    send_pixel(FACE_PZ, 12'd511, 12'd0);
    send_pixel(FACE_NZ, 12'd0, 12'd511);
    // pixel past the face edge saturates
    send_pixel(FACE_ALT6, 12'hFFF, 12'hFFF);
    send_pixel(FACE_ALT7, 12'hFFF, 12'd0);
    // single-pixel face: direction is the face axis, exact zero vectors
    load_regs(1, 1, 1);
    for (int fc = 0; fc < 6; fc++) send_pixel(FACE_W'(fc), 12'd0, 12'd0);
    send_pixel(FACE_PY, 12'hFFF, 12'hFFF);
  endtask

  task automatic test_register_extremes();
    int setups[5][3] = '{'{0, 0, 0}, '{1, 1, 1}, '{8191, 16383, 8191},
                         '{4096, 8192, 4096}, '{2, 3, 4095}};
    foreach (setups[s]) begin
      load_regs(setups[s][0], setups[s][1], setups[s][2]);
      repeat (8) send_pixel(FACE_W'($urandom), pick_pixel(), pick_pixel());
    end
  endtask

  task automatic test_random_traffic();
    int setups[4][3] = '{'{512, 2048, 1024}, '{4096, 8192, 4096},
                         '{7, 13, 5}, '{100, 8191, 2900}};
    for (int phase = 0; phase < 4; phase++) begin
      // no idling, sender idle, receiver stall, both
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 60; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      foreach (setups[s]) begin
        load_regs(setups[s][0], setups[s][1], setups[s][2]);
        for (int n = 0; n < 96; n++) begin
          // let the pipe run dry once mid-stream
          if (phase == 1 && s == 0 && n == 48) begin
            in_valid <= 1'b0;
            while (pending_addrs.size() != 0) @(posedge clk);
          end
          send_pixel(FACE_W'($urandom), pick_pixel(), pick_pixel());
        end
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_traffic();
    drain();
    $display("covered %0d words in, %0d out: all face codes, register extremes,",
             words_in, words_out);
    $display("out-of-face pixels and four idle/stall mixes");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ cube_face_to_equirect_address_core.f @@
rtl/cfea_pkg.sv
rtl/cfea_coord_div.sv
rtl/cfea_cordic.sv
rtl/cfea_cdiv.sv
rtl/cube_face_to_equirect_address_core.sv
tb/tb_cube_face_to_equirect_address_core.sv
